// ===== design/rotor_cipher_substitution_unit_defines.svh =====
// Assertion macros for the rotor cipher substitution unit.
// Used by the top level only; no other dependencies.
`ifndef ROTOR_CIPHER_SUBSTITUTION_UNIT_DEFINES_SVH
`define ROTOR_CIPHER_SUBSTITUTION_UNIT_DEFINES_SVH
// Check an implication on every clock edge outside reset.
`define RCS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/rcs_pkg.sv =====
// Shared types and codes for the rotor cipher substitution unit.
// No dependencies.
package rcs_pkg;
  localparam int SymW = 5;
  typedef logic [SymW-1:0] sym_t;

  typedef enum logic [2:0] {
    FN_CIPHER  = 3'd0,
    FN_WR_FWD  = 3'd1,
    FN_WR_INV  = 3'd2,
    FN_WR_REFL = 3'd3,
    FN_WR_PLUG = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    REG_POS   = 2'd0,
    REG_FACE  = 2'd1,
    REG_SEQ   = 2'd2,
    REG_REFL  = 2'd3
  } reg_idx_t;

  // Which table a lookup request targets.
  typedef enum logic [1:0] {
    TB_PLUG = 2'd0,
    TB_FWD  = 2'd1,
    TB_INV  = 2'd2,
    TB_REFL = 2'd3
  } tbl_t;

  typedef struct packed {
    logic  rd;
    tbl_t  tbl;
    logic  [3:0] unit;
    logic  face;
    sym_t  idx;
  } lookup_req_t;
endpackage

// ===== design/rcs_tables.sv =====
// Wiring, reflector and plugboard memories of the rotor cipher unit.
// Depends on rcs_pkg. One request per cycle (a read, plus a write when wr_en), registered read.
module rcs_tables #(
  parameter int NUM_ROTORS     = 10,
  parameter int ALPHABET_SIZE  = 30,
  parameter int NUM_REFLECTORS = 3
) (
  input  logic                clk,
  input  rcs_pkg::lookup_req_t req,
  input  logic                wr_en,
  input  rcs_pkg::sym_t        wr_data,
  output rcs_pkg::sym_t        rd_data
);
  import rcs_pkg::*;
  localparam int RotDepth = NUM_ROTORS * 2 * ALPHABET_SIZE;
  localparam int RefDepth = NUM_REFLECTORS * ALPHABET_SIZE;
  localparam int RotAw = $clog2(RotDepth);
  localparam int RefAw = (RefDepth > 1) ? $clog2(RefDepth) : 1;
  localparam int PlugAw = $clog2(ALPHABET_SIZE);

  sym_t fwd_mem [RotDepth];
  sym_t inv_mem [RotDepth];
  sym_t refl_mem [RefDepth];
  sym_t plug_mem [ALPHABET_SIZE];

  logic [RotAw-1:0] rot_addr;
  logic [RefAw-1:0] ref_addr;
  logic [PlugAw-1:0] plug_addr;
  tbl_t sel_r;
  sym_t fwd_q, inv_q, refl_q, plug_q;

  assign rot_addr = RotAw'((32'(req.unit) * 2 + 32'(req.face)) * ALPHABET_SIZE
                           + 32'(req.idx));
  assign ref_addr = RefAw'(32'(req.unit) * ALPHABET_SIZE + 32'(req.idx));
  assign plug_addr = PlugAw'(req.idx);

  always_ff @(posedge clk) begin
    if (wr_en && req.tbl == TB_FWD) fwd_mem[rot_addr] <= wr_data;
    if (wr_en && req.tbl == TB_INV) inv_mem[rot_addr] <= wr_data;
    if (wr_en && req.tbl == TB_REFL) refl_mem[ref_addr] <= wr_data;
    if (wr_en && req.tbl == TB_PLUG) plug_mem[plug_addr] <= wr_data;
    fwd_q  <= fwd_mem[rot_addr];
    inv_q  <= inv_mem[rot_addr];
    refl_q <= refl_mem[ref_addr];
    plug_q <= plug_mem[plug_addr];
    sel_r  <= req.tbl;
  end

  always_comb begin
    case (sel_r)
      TB_FWD:  rd_data = fwd_q;
      TB_INV:  rd_data = inv_q;
      TB_REFL: rd_data = refl_q;
      default: rd_data = plug_q;
    endcase
  end
endmodule

// ===== design/rcs_seq.sv =====
// Sequencer of the rotor cipher unit: walks one symbol through 23 lookups.
// Depends on rcs_pkg; drives rcs_tables through a lookup request.
module rcs_seq #(
  parameter int NUM_ROTORS     = 10,
  parameter int ALPHABET_SIZE  = 30,
  parameter int NUM_REFLECTORS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rcs_pkg::sym_t         start_sym,
  input  logic [5*NUM_ROTORS-1:0] pos,
  input  logic [NUM_ROTORS-1:0]   faces,
  input  logic [4*NUM_ROTORS-1:0] seq,
  input  logic [1:0]           refl_sel,
  input  rcs_pkg::sym_t         rd_data,
  output rcs_pkg::lookup_req_t  req,
  output logic                 busy,
  output logic                 done,
  output rcs_pkg::sym_t         result
);
  import rcs_pkg::*;
  localparam int StepW = $clog2(2 * NUM_ROTORS + 3);
  localparam int LastStep = 2 * NUM_ROTORS + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_REQ  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  sym_t x_r, x_nxt;

  logic [3:0] slot, rotor;
  logic [4:0] raw_pos;
  sym_t offs, sum6_lo, back;
  logic [5:0] sum6, dif6;
  logic [1:0] refl;
  logic fwd_phase, back_phase;

  // step 0: plugboard in; 1..N forward; N+1 reflector; N+2..2N+1 backward
  // and the final plugboard is step 2N+2 (== LastStep+1).
  assign fwd_phase  = (step_r >= StepW'(1)) && (step_r <= StepW'(NUM_ROTORS));
  assign back_phase = (step_r >= StepW'(NUM_ROTORS + 2)) && (step_r <= StepW'(LastStep));

  always_comb begin
    slot = '0;
    if (fwd_phase) slot = 4'(step_r - StepW'(1));
    else if (back_phase) slot = 4'(StepW'(LastStep) - step_r);
  end

  assign rotor = (seq[slot*4 +: 4] >= 4'(NUM_ROTORS)) ? 4'(NUM_ROTORS - 1)
                                                     : seq[slot*4 +: 4];
  assign raw_pos = pos[rotor*5 +: 5];
  assign offs = (raw_pos >= 5'(ALPHABET_SIZE)) ? 5'(raw_pos - 5'(ALPHABET_SIZE)) : raw_pos;
  assign sum6 = 6'(x_r) + 6'(offs);
  assign sum6_lo = (sum6 >= 6'(ALPHABET_SIZE)) ? 5'(sum6 - 6'(ALPHABET_SIZE)) : 5'(sum6);
  assign refl = (3'(refl_sel) >= 3'(NUM_REFLECTORS)) ? 2'(NUM_REFLECTORS - 1) : refl_sel;

  // Undo the rotor offset on the lookup just returned.
  assign dif6 = 6'(rd_data) + 6'(ALPHABET_SIZE) - 6'(offs);
  assign back = (dif6 >= 6'(ALPHABET_SIZE)) ? 5'(dif6 - 6'(ALPHABET_SIZE)) : 5'(dif6);

  always_comb begin
    req = '0;
    req.rd = (state_r == S_REQ);
    req.face = faces[rotor];
    req.unit = rotor;
    req.idx = sum6_lo;
    if (fwd_phase) req.tbl = TB_FWD;
    else if (back_phase) req.tbl = TB_INV;
    else if (step_r == StepW'(NUM_ROTORS + 1)) begin
      req.tbl = TB_REFL;
      req.unit = 4'(refl);
      req.idx = x_r;
    end else begin
      req.tbl = TB_PLUG;
      req.idx = x_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    x_nxt = x_r;
    done = 1'b0;
    case (state_r)
      S_IDLE: if (start) begin
        state_nxt = S_REQ;
        step_nxt = '0;
        x_nxt = (start_sym >= 5'(ALPHABET_SIZE)) ? 5'(start_sym - 5'(ALPHABET_SIZE))
                                                 : start_sym;
      end
      S_REQ: state_nxt = S_WAIT;
      S_WAIT: begin
        x_nxt = (fwd_phase || back_phase) ? back : rd_data;
        if (step_r == StepW'(LastStep + 1)) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          step_nxt = step_r + StepW'(1);
          state_nxt = S_REQ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign result = rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
    x_r <= x_nxt;
  end
endmodule

// ===== design/rotor_cipher_substitution_unit.sv =====
// Top level of the rotor cipher substitution unit.
// Depends on rcs_pkg, rcs_tables, rcs_seq and the defines header.
//
// Usage: requests enter on in_* (tdata holds symbol, unit, face, entry_index,
// entry_value from the low bits up; func travels in tuser). Each request gives one
// result on out_*: the substituted symbol with tuser=1 for a cipher request,
// zero with tuser=0 for a table write or an unknown code.
// Configuration writes on cfg_* (index 0 positions, 1 faces, 2 rotor order,
// 3 reflector select) are taken at any time and must be done while idle.
// A write request is answered from the output register. A cipher request makes
// 2*NUM_ROTORS+3 table lookups, each a request state then a wait state, through
// the single shared table read port, and its result goes to the output register.
// The block takes one request at a time; in_tready is low while a request
// is in work or its result has not been taken. A stalled receiver holds the
// result in the output register. Reset clears control state and config
// registers to their reset values; tables are undefined until written.
module rotor_cipher_substitution_unit #(
  parameter int NUM_ROTORS     = 10,
  parameter int ALPHABET_SIZE  = 30,
  parameter int NUM_REFLECTORS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // symbol[4:0], unit[8:5], face[9], index[14:10], value[19:15]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_symbol[4:0]
  output logic        out_tuser,  // is_cipher_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import rcs_pkg::*;
  `include "rotor_cipher_substitution_unit_defines.svh"

  logic [5*NUM_ROTORS-1:0] pos_r;
  logic [NUM_ROTORS-1:0]   face_r;
  logic [4*NUM_ROTORS-1:0] seq_r;
  logic [1:0]              refl_r;

  logic out_valid_r;
  sym_t out_sym_r;
  logic out_cip_r;

  func_t fn;
  sym_t in_sym, in_idx, in_val;
  logic [3:0] in_unit;
  logic in_face, accept, wr_ok, seq_busy, seq_done;
  lookup_req_t seq_req, tbl_req;
  sym_t rd_data, seq_res;
  logic [5:0] val6;

  assign fn = func_t'(in_tuser);
  assign in_sym = in_tdata[4:0];
  assign in_unit = in_tdata[8:5];
  assign in_face = in_tdata[9];
  assign in_idx = in_tdata[14:10];
  assign in_val = in_tdata[19:15];
  assign val6 = 6'(in_val);

  assign in_tready = !seq_busy && !out_valid_r;
  assign accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Drop writes that name no entry, rotor or reflector.
  always_comb begin
    wr_ok = 1'b0;
    if (6'(in_idx) < 6'(ALPHABET_SIZE)) begin
      case (fn)
        FN_WR_FWD, FN_WR_INV: wr_ok = in_unit < 4'(NUM_ROTORS);
        FN_WR_REFL:           wr_ok = in_unit < 4'(NUM_REFLECTORS);
        FN_WR_PLUG:           wr_ok = 1'b1;
        default:              wr_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    tbl_req = seq_req;
    if (!seq_busy) begin
      tbl_req.rd = 1'b0;
      tbl_req.unit = in_unit;
      tbl_req.face = in_face;
      tbl_req.idx = in_idx;
      case (fn)
        FN_WR_FWD:  tbl_req.tbl = TB_FWD;
        FN_WR_INV:  tbl_req.tbl = TB_INV;
        FN_WR_REFL: tbl_req.tbl = TB_REFL;
        default:    tbl_req.tbl = TB_PLUG;
      endcase
    end
  end

  rcs_tables #(
    .NUM_ROTORS(NUM_ROTORS), .ALPHABET_SIZE(ALPHABET_SIZE),
    .NUM_REFLECTORS(NUM_REFLECTORS)
  ) u_tables (
    .clk(clk), .req(tbl_req), .wr_en(accept && wr_ok),
    .wr_data((val6 >= 6'(ALPHABET_SIZE)) ? 5'(val6 - 6'(ALPHABET_SIZE)) : in_val),
    .rd_data(rd_data)
  );

  rcs_seq #(
    .NUM_ROTORS(NUM_ROTORS), .ALPHABET_SIZE(ALPHABET_SIZE),
    .NUM_REFLECTORS(NUM_REFLECTORS)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .start(accept && fn == FN_CIPHER),
    .start_sym(in_sym), .pos(pos_r), .faces(face_r), .seq(seq_r),
    .refl_sel(refl_r), .rd_data(rd_data), .req(seq_req), .busy(seq_busy),
    .done(seq_done), .result(seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      face_r <= '0;
      for (int i = 0; i < NUM_ROTORS; i++) seq_r[i*4 +: 4] <= 4'(i);
      refl_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_POS:  pos_r <= cfg_data[5*NUM_ROTORS-1:0];
          REG_FACE: face_r <= cfg_data[NUM_ROTORS-1:0];
          REG_SEQ:  seq_r <= cfg_data[4*NUM_ROTORS-1:0];
          REG_REFL: refl_r <= cfg_data[1:0];
          default:  ;
        endcase
      end
      // Hold the result until the receiver takes it.
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (seq_done || (accept && fn != FN_CIPHER)) out_valid_r <= 1'b1;
    end
    if (seq_done) begin
      out_sym_r <= seq_res;
      out_cip_r <= 1'b1;
    end else if (accept && fn != FN_CIPHER) begin
      out_sym_r <= '0;
      out_cip_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {3'b000, out_sym_r};
  assign out_tuser = out_cip_r;

  `RCS_ASSERT_IMP(a_no_accept_busy, clk, rst_n, seq_busy, !in_tready, "accept while busy")
  `RCS_ASSERT_IMP(a_done_free_out, clk, rst_n, seq_done, !out_valid_r, "result overrun")
  `RCS_ASSERT_NEXT(a_write_ack, clk, rst_n, accept && fn != FN_CIPHER,
                   out_valid_r && !out_cip_r, "write not acknowledged")
endmodule
